// ===== rtl/eavc_pkg.sv =====
`timescale 1ns / 1ps
package eavc_pkg;

  localparam int ENTRIES_DEF  = 8;
  localparam int KEY_BITS_DEF = 32;

  localparam int TICK_W  = 32;
  localparam int HALF_W  = 16;
  localparam int PROP_W  = 3;
  localparam int FLAG_W  = 2;
  localparam int VALUE_W = 17;
  localparam int SLOT_W  = 3;
  localparam int COUNT_W = 32;

  localparam logic [TICK_W-1:0] EXPIRY_RST = 32'd1000;

  localparam logic KIND_CACHED = 1'b0;
  localparam logic KIND_DIRECT = 1'b1;

  localparam logic [PROP_W-1:0] PROP_X       = 3'd0;
  localparam logic [PROP_W-1:0] PROP_Y       = 3'd1;
  localparam logic [PROP_W-1:0] PROP_WIDTH   = 3'd2;
  localparam logic [PROP_W-1:0] PROP_HEIGHT  = 3'd3;
  localparam logic [PROP_W-1:0] PROP_ENABLED = 3'd4;
  localparam logic [PROP_W-1:0] PROP_VISIBLE = 3'd5;

  // Verdict of the entry probe on one examined entry
  typedef struct packed {
    logic live;
    logic expired;
    logic hit;
  } probe_res_t;

  // Select one property from a packed record: x/y sign-extended, flags as 0 or 1
  function automatic logic [VALUE_W-1:0] pick_value(
    input logic [PROP_W-1:0] prop,
    input logic [TICK_W-1:0] pos,
    input logic [TICK_W-1:0] size,
    input logic [FLAG_W-1:0] flags
  );
    logic [VALUE_W-1:0] v;
    unique case (prop)
      PROP_X:       v = {pos[HALF_W-1], pos[HALF_W-1:0]};
      PROP_Y:       v = {pos[TICK_W-1], pos[TICK_W-1:HALF_W]};
      PROP_WIDTH:   v = {1'b0, size[HALF_W-1:0]};
      PROP_HEIGHT:  v = {1'b0, size[TICK_W-1:HALF_W]};
      PROP_ENABLED: v = {{(VALUE_W-1){1'b0}}, flags[0]};
      PROP_VISIBLE: v = {{(VALUE_W-1){1'b0}}, flags[1]};
      default:      v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/eavc_if.sv =====
`timescale 1ns / 1ps
interface eavc_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [31:0]        key;
  logic [2:0]         property_req;
  logic [31:0]        now_tick;
  logic signed [15:0] fill_x;
  logic signed [15:0] fill_y;
  logic [15:0]        fill_width;
  logic [15:0]        fill_height;
  logic               fill_enabled;
  logic               fill_visible;

  modport source (
    output valid, kind, key, property_req, now_tick, fill_x, fill_y,
           fill_width, fill_height, fill_enabled, fill_visible,
    input  ready
  );
  modport sink (
    input  valid, kind, key, property_req, now_tick, fill_x, fill_y,
           fill_width, fill_height, fill_enabled, fill_visible,
    output ready
  );
endinterface

interface eavc_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] value;
  logic               served_from_cache;
  logic [2:0]         slot;
  logic [31:0]        hit_total;
  logic [31:0]        miss_total;

  modport source (
    output valid, value, served_from_cache, slot, hit_total, miss_total,
    input  ready
  );
  modport sink (
    input  valid, value, served_from_cache, slot, hit_total, miss_total,
    output ready
  );
endinterface

// ===== rtl/eavc_ram.sv =====
`timescale 1ns / 1ps
module eavc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/eavc_probe.sv =====
`timescale 1ns / 1ps
module eavc_probe import eavc_pkg::*; #(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                ent_valid,
  input  logic [KEY_BITS-1:0] ent_key,
  input  logic [TICK_W-1:0]   ent_stamp,
  input  logic [KEY_BITS-1:0] req_key,
  input  logic [TICK_W-1:0]   now,
  input  logic [TICK_W-1:0]   expiry,
  output probe_res_t          res
);

  logic [TICK_W-1:0] age;
  logic              too_old;

  // Modular age, so a wrapped tick still gives the right distance
  assign age     = now - ent_stamp;
  assign too_old = age > expiry;

  assign res.live    = ent_valid;
  assign res.expired = ent_valid && too_old;
  assign res.hit     = ent_valid && !too_old && (ent_key == req_key);

endmodule

// ===== rtl/expiring_assoc_value_cache_unit.sv =====
`timescale 1ns / 1ps
// A direct item goes from acceptance straight to the result; a cached hit on entry i
// ends the scan at that entry; a cached miss scans all ENTRIES entries, then fills.
// Throughput: one item at a time, set by the single probe unit that examines one
// entry per cycle as it comes out of the record RAM, plus the fill write.
// Reset (rst_n, synchronous, active low): all entries empty, counters zero,
// expiry back to 1000 ticks, no result pending. The record RAM is not cleared.
module expiring_assoc_value_cache_unit import eavc_pkg::*; #(
  parameter int ENTRIES  = ENTRIES_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  eavc_in_if.sink           in_item,
  eavc_out_if.source        out_item,
  input  logic              cfg_we,
  input  logic [TICK_W-1:0] cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Record layout in the RAM: {flags, size, position, stamp, key}
  localparam int STAMP_LO = KEY_BITS;
  localparam int POS_LO   = STAMP_LO + TICK_W;
  localparam int SIZE_LO  = POS_LO + TICK_W;
  localparam int FLAGS_LO = SIZE_LO + TICK_W;
  localparam int REC_W    = FLAGS_LO + FLAG_W;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_FILL = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Request held for the whole scan
  logic [KEY_BITS-1:0] req_key_r, req_key_nxt;
  logic [PROP_W-1:0]   req_prop_r, req_prop_nxt;
  logic [TICK_W-1:0]   req_now_r, req_now_nxt;
  logic [TICK_W-1:0]   req_pos_r, req_pos_nxt;
  logic [TICK_W-1:0]   req_size_r, req_size_nxt;
  logic [FLAG_W-1:0]   req_flags_r, req_flags_nxt;

  // Scan sequencer: ptr_r issues reads, chk_* tracks the entry whose data is out
  logic [IDX_W-1:0]    ptr_r, ptr_nxt;
  logic                issue_done_r, issue_done_nxt;
  logic                chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]    chk_idx_r, chk_idx_nxt;
  logic                free_vld_r, free_vld_nxt;
  logic [IDX_W-1:0]    free_idx_r, free_idx_nxt;

  logic [ENTRIES-1:0]  valid_r, valid_nxt;
  logic [COUNT_W-1:0]  hit_count_r, hit_count_nxt;
  logic [COUNT_W-1:0]  miss_count_r, miss_count_nxt;
  logic [TICK_W-1:0]   expiry_r, expiry_nxt;

  // Finished result, waiting for the output register
  logic [VALUE_W-1:0]  res_value_r, res_value_nxt;
  logic                res_cached_r, res_cached_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  logic                out_vld_r, out_vld_nxt;
  logic [VALUE_W-1:0]  out_value_r, out_value_nxt;
  logic                out_cached_r, out_cached_nxt;
  logic [SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [COUNT_W-1:0]  out_hits_r, out_hits_nxt;
  logic [COUNT_W-1:0]  out_misses_r, out_misses_nxt;

  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [REC_W-1:0]    ram_wdata;
  logic [REC_W-1:0]    ram_rdata;
  logic [IDX_W-1:0]    fill_idx;
  probe_res_t          probe;

  // Fill goes to the last free slot seen, or overwrites slot 0 when full
  assign fill_idx  = free_vld_r ? free_idx_r : '0;
  assign ram_we    = (state_r == ST_FILL);
  assign ram_waddr = fill_idx;
  assign ram_wdata = {req_flags_r, req_size_r, req_pos_r, req_now_r, req_key_r};

  eavc_ram #(
    .WIDTH (REC_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // One entry per cycle through the shared age / key compare
  eavc_probe #(
    .KEY_BITS (KEY_BITS)
  ) u_probe (
    .ent_valid (valid_r[chk_idx_r]),
    .ent_key   (ram_rdata[KEY_BITS-1:0]),
    .ent_stamp (ram_rdata[STAMP_LO +: TICK_W]),
    .req_key   (req_key_r),
    .now       (req_now_r),
    .expiry    (expiry_r),
    .res       (probe)
  );

  assign in_item.ready              = (state_r == ST_IDLE);
  assign out_item.valid             = out_vld_r;
  assign out_item.value             = out_value_r;
  assign out_item.served_from_cache = out_cached_r;
  assign out_item.slot              = out_slot_r;
  assign out_item.hit_total         = out_hits_r;
  assign out_item.miss_total        = out_misses_r;

  always_comb begin
    state_nxt      = state_r;
    req_key_nxt    = req_key_r;
    req_prop_nxt   = req_prop_r;
    req_now_nxt    = req_now_r;
    req_pos_nxt    = req_pos_r;
    req_size_nxt   = req_size_r;
    req_flags_nxt  = req_flags_r;
    ptr_nxt        = ptr_r;
    issue_done_nxt = issue_done_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    free_vld_nxt   = free_vld_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    hit_count_nxt  = hit_count_r;
    miss_count_nxt = miss_count_r;
    expiry_nxt     = cfg_we ? cfg_wdata : expiry_r;
    res_value_nxt  = res_value_r;
    res_cached_nxt = res_cached_r;
    res_slot_nxt   = res_slot_r;
    out_vld_nxt    = out_vld_r && !out_item.ready;
    out_value_nxt  = out_value_r;
    out_cached_nxt = out_cached_r;
    out_slot_nxt   = out_slot_r;
    out_hits_nxt   = out_hits_r;
    out_misses_nxt = out_misses_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_item.valid) begin
          req_key_nxt   = KEY_BITS'(in_item.key);
          req_prop_nxt  = in_item.property_req;
          req_now_nxt   = in_item.now_tick;
          req_pos_nxt   = {in_item.fill_y, in_item.fill_x};
          req_size_nxt  = {in_item.fill_height, in_item.fill_width};
          req_flags_nxt = {in_item.fill_visible, in_item.fill_enabled};
          if (in_item.kind == KIND_DIRECT) begin
            // Bypass: answer from the fill fields, leave the cache alone
            res_value_nxt  = pick_value(in_item.property_req,
                                        {in_item.fill_y, in_item.fill_x},
                                        {in_item.fill_height, in_item.fill_width},
                                        {in_item.fill_visible, in_item.fill_enabled});
            res_cached_nxt = 1'b0;
            res_slot_nxt   = '0;
            state_nxt      = ST_DONE;
          end else begin
            ptr_nxt        = '0;
            issue_done_nxt = 1'b0;
            free_vld_nxt   = 1'b0;
            state_nxt      = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // Issue the next read while the previous entry is examined
        if (!issue_done_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = ptr_r;
          if (ptr_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            ptr_nxt = ptr_r + 1'b1;
          end
        end
        if (chk_vld_r) begin
          priority if (!probe.live) begin
            free_vld_nxt = 1'b1;
            free_idx_nxt = chk_idx_r;
          end else if (probe.expired) begin
            // Drop the stale record and note its slot
            valid_nxt[chk_idx_r] = 1'b0;
            free_vld_nxt         = 1'b1;
            free_idx_nxt         = chk_idx_r;
          end else if (probe.hit) begin
            hit_count_nxt  = hit_count_r + 1'b1;
            res_value_nxt  = pick_value(req_prop_r, ram_rdata[POS_LO +: TICK_W],
                                        ram_rdata[SIZE_LO +: TICK_W],
                                        ram_rdata[FLAGS_LO +: FLAG_W]);
            res_cached_nxt = 1'b1;
            res_slot_nxt   = SLOT_W'(chk_idx_r);
          end else begin
            // Live entry of another object: move on
          end
          if (probe.hit) begin
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_DONE;
          end else if (chk_idx_r == LAST_IDX) begin
            chk_vld_nxt = 1'b0;
            state_nxt   = ST_FILL;
          end
        end
      end

      ST_FILL: begin
        valid_nxt[fill_idx] = 1'b1;
        miss_count_nxt      = miss_count_r + 1'b1;
        res_value_nxt       = pick_value(req_prop_r, req_pos_r, req_size_r, req_flags_r);
        res_cached_nxt      = 1'b0;
        res_slot_nxt        = SLOT_W'(fill_idx);
        state_nxt           = ST_DONE;
      end

      ST_DONE: begin
        // Hold the result until the output register is free
        if (!out_vld_r || out_item.ready) begin
          out_vld_nxt    = 1'b1;
          out_value_nxt  = res_value_r;
          out_cached_nxt = res_cached_r;
          out_slot_nxt   = res_slot_r;
          out_hits_nxt   = hit_count_r;
          out_misses_nxt = miss_count_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_done_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      free_vld_r   <= 1'b0;
      valid_r      <= '0;
      hit_count_r  <= '0;
      miss_count_r <= '0;
      expiry_r     <= EXPIRY_RST;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      chk_vld_r    <= chk_vld_nxt;
      free_vld_r   <= free_vld_nxt;
      valid_r      <= valid_nxt;
      hit_count_r  <= hit_count_nxt;
      miss_count_r <= miss_count_nxt;
      expiry_r     <= expiry_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_key_r    <= req_key_nxt;
    req_prop_r   <= req_prop_nxt;
    req_now_r    <= req_now_nxt;
    req_pos_r    <= req_pos_nxt;
    req_size_r   <= req_size_nxt;
    req_flags_r  <= req_flags_nxt;
    ptr_r        <= ptr_nxt;
    chk_idx_r    <= chk_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    res_value_r  <= res_value_nxt;
    res_cached_r <= res_cached_nxt;
    res_slot_r   <= res_slot_nxt;
    out_value_r  <= out_value_nxt;
    out_cached_r <= out_cached_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hits_r   <= out_hits_nxt;
    out_misses_r <= out_misses_nxt;
  end

`ifndef SYNTHESIS
  // A direct item never touches the scan: it goes straight to the result
  a_direct_skips_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_item.valid && in_item.ready && in_item.kind == KIND_DIRECT) |=> state_r == ST_DONE)
    else $error("direct item did not go straight to result");

  // At most one of the two counters moves per cycle
  a_one_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (hit_count_r == $past(hit_count_r)) || (miss_count_r == $past(miss_count_r)))
    else $error("hit and miss counters moved together");

  // A noted free slot is still empty when the fill lands
  a_fill_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && free_vld_r) |-> !valid_r[free_idx_r])
    else $error("fill targets a live entry");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import eavc_pkg::*;

  localparam int LINES    = ENTRIES_DEF;
  localparam int KEY_POOL = 11;

  // One request as the sender offers it
  typedef struct {
    logic               kind;
    logic [31:0]        key;
    logic [2:0]         prop;
    logic [31:0]        now;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic               en;
    logic               vis;
  } cache_req_t;

  // Property record held by one cache line
  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        w;
    logic [15:0]        h;
    logic               en;
    logic               vis;
  } prop_rec_t;

  typedef struct {
    logic        valid;
    logic [31:0] key;
    logic [31:0] stamp;
    prop_rec_t   rec;
  } cache_line_t;

  // One result as the block should deliver it
  typedef struct {
    logic signed [16:0] value;
    logic               served;
    logic [2:0]         slot;
    logic [31:0]        hits;
    logic [31:0]        misses;
  } lookup_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TICK_W-1:0] cfg_wdata;

  eavc_in_if  in_if ();
  eavc_out_if out_if ();

  expiring_assoc_value_cache_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_if),
    .out_item  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor state: our own copy of the lines, counters and expiry
  cache_line_t lines [LINES];
  logic [31:0] expiry_ticks;
  logic [31:0] hit_count;
  logic [31:0] miss_count;

  lookup_res_t expected_q[$];
  int          err_count;

  // Traffic shaping, shared between the test tasks and the two drivers
  bit          tx_idle;
  bit          rx_idle;
  int          rx_hold_left;
  int          rx_stall_left;
  logic [31:0] cur_tick;
  logic [31:0] key_pool [KEY_POOL];

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #(3_000_000);
    $display("testbench: FAIL");
    $finish;
  end

  // Pick one property out of a record; positions sign-extend, sizes zero-extend
  function automatic logic signed [16:0] select_prop(input logic [2:0] prop,
                                                     input prop_rec_t rec);
    logic signed [16:0] v;
    case (prop)
      PROP_X:       v = rec.x;
      PROP_Y:       v = rec.y;
      PROP_WIDTH:   v = {1'b0, rec.w};
      PROP_HEIGHT:  v = {1'b0, rec.h};
      PROP_ENABLED: v = {16'd0, rec.en};
      PROP_VISIBLE: v = {16'd0, rec.vis};
      default:      v = '0;
    endcase
    return v;
  endfunction

  // Work out the result of one accepted item and advance the predicted cache
  function automatic lookup_res_t predict_lookup(input cache_req_t r);
    lookup_res_t res;
    prop_rec_t   rec;
    logic [31:0] age;
    int          free_idx;
    int          i;
    bit          found;
    rec.x   = r.x;
    rec.y   = r.y;
    rec.w   = r.w;
    rec.h   = r.h;
    rec.en  = r.en;
    rec.vis = r.vis;
    res.value  = select_prop(r.prop, rec);
    res.served = 1'b0;
    res.slot   = '0;
    res.hits   = hit_count;
    res.misses = miss_count;
    if (r.kind == KIND_DIRECT) begin
      return res;
    end
    free_idx = -1;
    found    = 1'b0;
    // Scan in index order; a hit stops the scan, so later lines keep their age
    for (i = 0; i < LINES; i++) begin
      if (!found) begin
        age = r.now - lines[i].stamp;
        if (!lines[i].valid) begin
          free_idx = i;
        end else if (age > expiry_ticks) begin
          lines[i].valid = 1'b0;
          free_idx = i;
        end else if (lines[i].key == r.key) begin
          found      = 1'b1;
          hit_count  = hit_count + 1;
          res.value  = select_prop(r.prop, lines[i].rec);
          res.served = 1'b1;
          res.slot   = i[2:0];
          res.hits   = hit_count;
        end
      end
    end
    if (!found) begin
      // No free line noted: overwrite line zero
      if (free_idx < 0) free_idx = 0;
      miss_count = miss_count + 1;
      lines[free_idx].valid = 1'b1;
      lines[free_idx].key   = r.key;
      lines[free_idx].stamp = r.now;
      lines[free_idx].rec   = rec;
      res.slot   = free_idx[2:0];
      res.misses = miss_count;
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    err_count++;
    $display("[%0t] mismatch: %s expected %h got %h", $realtime, what, want, got);
  endtask

  // Gap length: mostly a few cycles, now and then a long one
  function automatic int pick_gap_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic cache_req_t random_req();
    cache_req_t r;
    r.kind = 1'($urandom_range(0, 1));
    r.key  = $urandom;
    r.prop = 3'($urandom_range(0, 7));
    r.now  = $urandom;
    r.x    = 16'($urandom);
    r.y    = 16'($urandom);
    r.w    = 16'($urandom);
    r.h    = 16'($urandom);
    r.en   = 1'($urandom_range(0, 1));
    r.vis  = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Cached lookup with random current values for the fill
  function automatic cache_req_t cached_req(input logic [31:0] key, input logic [2:0] prop,
                                            input logic [31:0] now);
    cache_req_t r;
    r      = random_req();
    r.kind = KIND_CACHED;
    r.key  = key;
    r.prop = prop;
    r.now  = now;
    return r;
  endfunction

  // Offer one item, hold it until accepted, then at times idle for a random gap.
  // Valid stays high when no gap follows so back-to-back items need one drive.
  task automatic send_item(input cache_req_t r);
    int gap;
    in_if.valid        <= 1'b1;
    in_if.kind         <= r.kind;
    in_if.key          <= r.key;
    in_if.property_req <= r.prop;
    in_if.now_tick     <= r.now;
    in_if.fill_x       <= r.x;
    in_if.fill_y       <= r.y;
    in_if.fill_width   <= r.w;
    in_if.fill_height  <= r.h;
    in_if.fill_enabled <= r.en;
    in_if.fill_visible <= r.vis;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    expected_q.push_back(predict_lookup(r));
    gap = 0;
    if (tx_idle && $urandom_range(0, 99) < 40) gap = pick_gap_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every expected result has arrived
  task automatic wait_for_results();
    int n;
    in_if.valid <= 1'b0;
    n = 0;
    while (expected_q.size() != 0 && n < 50000) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  // Only ever called with the block idle
  task automatic write_expiry(input logic [31:0] ticks);
    cfg_we    <= 1'b1;
    cfg_wdata <= ticks;
    @(posedge clk);
    cfg_we       <= 1'b0;
    expiry_ticks = ticks;
    @(posedge clk);
  endtask

  function automatic logic [31:0] tick_step(input logic [31:0] e);
    if (e == 0) return $urandom_range(0, 1);
    if ($urandom_range(0, 19) == 0) return $urandom;
    if (e > 32'd1_000_000) return $urandom_range(0, 1000);
    return $urandom_range(0, e / 3 + 1);
  endfunction

  // Fresh set of keys per phase: small, nearly all-ones and fully random
  task automatic refill_key_pool();
    int i;
    for (i = 0; i < KEY_POOL; i++) begin
      case ($urandom_range(0, 2))
        0:       key_pool[i] = $urandom_range(0, 15);
        1:       key_pool[i] = ~32'($urandom_range(0, 15));
        default: key_pool[i] = $urandom;
      endcase
    end
  endtask

  // Empty cache: misses fill from the top line down, the ninth key lands in line zero
  task automatic test_full_cache_eviction();
    logic [31:0] keys [9];
    int i;
    keys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_0001,
             32'h8000_0000, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'h1234_5678};
    for (i = 0; i < 9; i++) begin
      cur_tick = cur_tick + 1;
      send_item(cached_req(keys[i], 3'(i % 8), cur_tick));
    end
    send_item(cached_req(keys[1], PROP_Y, cur_tick));
  endtask

  // A hit answers with the stored record, not with the new fill values
  task automatic test_fill_then_hit();
    cache_req_t r;
    cur_tick = cur_tick + 5;
    r      = cached_req(32'hC0DE_0001, PROP_X, cur_tick);
    r.x    = -16'sd32768;
    r.y    = 16'sd32767;
    send_item(r);
    r      = cached_req(32'hC0DE_0001, PROP_X, cur_tick + 2);
    r.x    = 16'sd12;
    send_item(r);
  endtask

  // Every property, unknown ones too, with the fill fields at their extremes
  task automatic test_direct_reads();
    cache_req_t r;
    int p;
    for (p = 0; p < 8; p++) begin
      r      = random_req();
      r.kind = KIND_DIRECT;
      r.prop = 3'(p);
      r.now  = cur_tick;
      if (p % 2 == 0) begin
        r.x = -16'sd32768; r.y = 16'sd32767; r.w = 16'hFFFF; r.h = 16'hFFFF;
        r.en = 1'b1; r.vis = 1'b1;
      end else begin
        r.x = 16'sd32767; r.y = -16'sd32768; r.w = 16'h0000; r.h = 16'h0000;
        r.en = 1'b0; r.vis = 1'b0;
      end
      send_item(r);
    end
  endtask

  // Zero expiry, maximum expiry and an age measured across the tick wrap
  task automatic test_expiry_edges();
    wait_for_results();
    write_expiry(32'd0);
    cur_tick = cur_tick + 10;
    send_item(cached_req(32'h7777_0000, PROP_WIDTH, cur_tick));
    send_item(cached_req(32'h7777_0000, PROP_WIDTH, cur_tick));
    cur_tick = cur_tick + 1;
    send_item(cached_req(32'h7777_0000, PROP_HEIGHT, cur_tick));
    wait_for_results();
    write_expiry(32'hFFFF_FFFF);
    send_item(cached_req(32'h7777_0000, PROP_ENABLED, cur_tick + 32'h8000_0000));
    wait_for_results();
    write_expiry(32'd10);
    send_item(cached_req(32'h0BAD_F00D, PROP_VISIBLE, 32'hFFFF_FFFF));
    send_item(cached_req(32'h0BAD_F00D, PROP_Y, 32'd5));
    wait_for_results();
    write_expiry(EXPIRY_RST);
  endtask

  // Stall the receiver for a long stretch while items keep coming back to back
  task automatic test_backpressure();
    int i;
    wait_for_results();
    tx_idle      = 1'b0;
    rx_hold_left = 300;
    for (i = 0; i < 20; i++) begin
      cur_tick = cur_tick + $urandom_range(0, 50);
      send_item(cached_req(key_pool[$urandom_range(0, KEY_POOL - 1)],
                           3'($urandom_range(0, 7)), cur_tick));
    end
    // Sender pauses here until every result is out
    wait_for_results();
    tx_idle = 1'b1;
  endtask

  // Mostly well-formed lookups over a small key set with a steady tick,
  // the rest fully random noise
  task automatic test_random_traffic(input int n_items, input logic [31:0] ticks,
                                     input bit tx_on, input bit rx_on);
    cache_req_t r;
    int i;
    wait_for_results();
    write_expiry(ticks);
    refill_key_pool();
    tx_idle = tx_on;
    rx_idle = rx_on;
    for (i = 0; i < n_items; i++) begin
      r = random_req();
      if ($urandom_range(0, 99) < 85) begin
        r.kind   = ($urandom_range(0, 9) == 0) ? KIND_DIRECT : KIND_CACHED;
        r.key    = key_pool[$urandom_range(0, KEY_POOL - 1)];
        cur_tick = cur_tick + tick_step(ticks);
        r.now    = cur_tick;
      end
      send_item(r);
    end
    wait_for_results();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Receiver: long hold-off first, then random stalls, or always ready
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        out_if.ready <= 1'b0;
        rx_hold_left--;
      end else if (!rx_idle) begin
        out_if.ready <= 1'b1;
      end else if (rx_stall_left > 0) begin
        out_if.ready <= 1'b0;
        rx_stall_left--;
      end else begin
        out_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) rx_stall_left = pick_gap_len();
      end
    end
  end

  // Compare every delivered result with the oldest expectation
  always @(posedge clk) begin : check_results
    lookup_res_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result with nothing expected", 32'd0, 32'(out_if.slot));
      end else begin
        want = expected_q.pop_front();
        if (out_if.value !== want.value)
          report_mismatch("value", 32'(want.value), 32'(out_if.value));
        if (out_if.served_from_cache !== want.served)
          report_mismatch("served_from_cache", 32'(want.served),
                          32'(out_if.served_from_cache));
        if (out_if.slot !== want.slot)
          report_mismatch("slot", 32'(want.slot), 32'(out_if.slot));
        if (out_if.hit_total !== want.hits)
          report_mismatch("hit_total", want.hits, out_if.hit_total);
        if (out_if.miss_total !== want.misses)
          report_mismatch("miss_total", want.misses, out_if.miss_total);
      end
    end
  end

  initial begin
    int i;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_if.valid        <= 1'b0;
    in_if.kind         <= KIND_CACHED;
    in_if.key          <= '0;
    in_if.property_req <= PROP_X;
    in_if.now_tick     <= '0;
    in_if.fill_x       <= '0;
    in_if.fill_y       <= '0;
    in_if.fill_width   <= '0;
    in_if.fill_height  <= '0;
    in_if.fill_enabled <= 1'b0;
    in_if.fill_visible <= 1'b0;
    err_count     = 0;
    tx_idle       = 1'b1;
    rx_idle       = 1'b1;
    rx_hold_left  = 0;
    rx_stall_left = 0;
    // Start close to the top so the tick wraps early in the run
    cur_tick      = 32'hFFFF_F000;
    expiry_ticks  = EXPIRY_RST;
    hit_count     = '0;
    miss_count    = '0;
    for (i = 0; i < LINES; i++) begin
      lines[i].valid = 1'b0;
      lines[i].key   = '0;
      lines[i].stamp = '0;
      lines[i].rec   = '{x: '0, y: '0, w: '0, h: '0, en: 1'b0, vis: 1'b0};
    end
    refill_key_pool();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    test_full_cache_eviction();
    test_fill_then_hit();
    test_direct_reads();
    test_expiry_edges();
    test_backpressure();
    test_random_traffic(280, 32'd40, 1'b1, 1'b1);
    test_random_traffic(280, 32'd1000, 1'b0, 1'b0);
    test_random_traffic(280, 32'd0, 1'b1, 1'b1);
    test_random_traffic(280, 32'hFFFF_FFFF, 1'b1, 1'b1);
    test_random_traffic(280, $urandom_range(1, 100000), 1'b1, 1'b1);

    wait_for_results();
    repeat (20) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch("results never delivered", 32'd0, 32'(expected_q.size()));
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
